### hdl/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue.
// Compiled out when SYNTHESIS is defined.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of clk, ignoring cycles in reset.
`define SPQ_ASSERT(label, clk_i, rst_n, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk_i, prop, msg) \
	label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define SPQ_ASSERT(label, clk_i, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk_i, prop, msg)

`endif

`endif

### hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 16;
	localparam int TAG_BITS = 16;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int LVLS     = $clog2(DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                 opcode;
		logic [KEY_BITS-1:0] item_key;
		logic [TAG_BITS-1:0] item_tag;
	} req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] front_key;
		logic [TAG_BITS-1:0] front_tag;
		logic [CNT_BITS-1:0] entry_count;
		logic                is_empty;
		logic                found;
		status_t             status;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	// Operation broadcast to every cell; OP_NOP when no request takes effect.
	typedef struct packed {
		op_t    act;
		entry_t item;
	} bcast_t;

	// Per-cell position flags worked out around the row.
	typedef struct packed {
		logic occ;      // cell holds a live entry
		logic tail;     // first free cell
		logic left_gt;  // left neighbour's key is larger than the pushed key
		logic hit;      // a match lies at or before this cell
	} cell_pos_t;

endpackage

`default_nettype wire

### hdl/spq_cell.sv
`default_nettype none

module spq_cell (
	input  wire logic               clk,
	input  wire spq_pkg::bcast_t    bcast,
	input  wire spq_pkg::cell_pos_t pos,
	input  wire spq_pkg::entry_t    left,
	input  wire spq_pkg::entry_t    right,
	output logic                    gt,
	output logic                    match,
	output spq_pkg::entry_t         nxt,
	output spq_pkg::entry_t         entry
);

	spq_pkg::entry_t entry_q;

	assign gt    = pos.occ && (bcast.item.key < entry_q.key);
	assign match = pos.occ && (entry_q == bcast.item);
	assign entry = entry_q;

	// Push: shift right behind the insertion point; pop: shift left;
	// remove: shift left from the first match onwards.
	always_comb begin
		nxt = entry_q;
		case (bcast.act)
			spq_pkg::OP_PUSH: begin
				if (pos.left_gt) begin
					nxt = left;
				end else if (gt || pos.tail) begin
					nxt = bcast.item;
				end
			end
			spq_pkg::OP_POP: begin
				nxt = right;
			end
			spq_pkg::OP_REMOVE: begin
				if (pos.hit) begin
					nxt = right;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= nxt;
	end

endmodule

`default_nettype wire

### hdl/spq_prefix.sv
`default_nettype none

// Prefix OR over the cell row: bit i of hit is set when any match lies at or
// before cell i. Log-depth tree of OR stages.
module spq_prefix (
	input  wire logic [spq_pkg::DEPTH-1:0] match,
	output logic      [spq_pkg::DEPTH-1:0] hit
);

	logic [spq_pkg::DEPTH-1:0] lvl [spq_pkg::LVLS+1];

	assign lvl[0] = match;

	for (genvar l = 0; l < spq_pkg::LVLS; l++) begin : g_lvl
		for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign hit = lvl[spq_pkg::LVLS];

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
`default_nettype none

// Sorted priority queue: up to spq_pkg::DEPTH entries (key, tag) kept in
// ascending key order in a row of cells, cell 0 being the front; equal keys
// leave in arrival order. Every request word (push, pop, remove, no-op)
// yields exactly one response word reporting the front entry, the count, an
// empty flag, whether a remove found its entry, and a status: empty error
// for pop or remove on an empty queue, full error for push when full; an
// erroring request changes nothing. One request is taken per clock cycle:
// all cells compare the broadcast key and tag at once and each loads from
// itself, a neighbour or the request in that same cycle, with the
// first-match search for remove done by a log-depth prefix OR across the
// row. The response is registered on acceptance and held until it is read;
// a new request is taken while the previous response is being read, and
// requests stall only while an unread response sits in the output register.
// Entry storage is not cleared at reset; only the count and the response valid flag are.

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire spq_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output spq_pkg::rsp_t        rsp
);

	localparam int N = spq_pkg::DEPTH;

	logic [spq_pkg::CNT_BITS-1:0] count_q;
	logic [spq_pkg::CNT_BITS-1:0] count_d;
	logic                         rsp_valid_q;
	spq_pkg::rsp_t                rsp_q;
	spq_pkg::rsp_t                rsp_d;

	logic                         acc;
	logic                         full;
	logic                         empty;
	logic                         found;
	spq_pkg::status_t             status;
	spq_pkg::bcast_t              bcast;

	logic [N-1:0]                 occ;
	logic [N-1:0]                 gt;
	logic [N-1:0]                 match;
	logic [N-1:0]                 hit;
	spq_pkg::entry_t              nxt   [N];
	spq_pkg::entry_t              entry [N];

	// Take a new word whenever the output register is free or being drained.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign full      = (count_q == spq_pkg::CNT_BITS'(N));
	assign empty     = (count_q == '0);

	// Decide the action broadcast to the row; drop erroring requests.
	always_comb begin
		bcast.act  = spq_pkg::OP_NOP;
		bcast.item = '{key: req.item_key, tag: req.item_tag};
		status     = spq_pkg::ST_OK;
		if (acc) begin
			case (req.opcode)
				spq_pkg::OP_PUSH: begin
					if (full) begin
						status = spq_pkg::ST_FULL;
					end else begin
						bcast.act = spq_pkg::OP_PUSH;
					end
				end
				spq_pkg::OP_POP,
				spq_pkg::OP_REMOVE: begin
					if (empty) begin
						status = spq_pkg::ST_EMPTY;
					end else begin
						bcast.act = req.opcode;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Live cells sit below the count; the tail is the first free cell.
	for (genvar i = 0; i < N; i++) begin : g_cell
		spq_pkg::cell_pos_t pos;
		spq_pkg::entry_t    left;
		spq_pkg::entry_t    right;

		assign occ[i]  = count_q > spq_pkg::CNT_BITS'(i);
		assign pos.occ = occ[i];
		assign pos.hit = hit[i];

		if (i == 0) begin : g_front
			assign pos.tail    = !occ[0];
			assign pos.left_gt = 1'b0;
			assign left        = '0;
		end else begin : g_inner
			assign pos.tail    = occ[i-1] && !occ[i];
			assign pos.left_gt = gt[i-1];
			assign left        = entry[i-1];
		end

		// The last cell has no right neighbour; what it loads lies past the count.
		if (i == N - 1) begin : g_back
			assign right = entry[i];
		end else begin : g_mid
			assign right = entry[i+1];
		end

		spq_cell u_cell (
			.clk   (clk),
			.bcast (bcast),
			.pos   (pos),
			.left  (left),
			.right (right),
			.gt    (gt[i]),
			.match (match[i]),
			.nxt   (nxt[i]),
			.entry (entry[i])
		);
	end

	spq_prefix u_prefix (
		.match (match),
		.hit   (hit)
	);

	assign found = (bcast.act == spq_pkg::OP_REMOVE) && hit[N-1];

	// Advance the count with the action that really happened.
	always_comb begin
		count_d = count_q;
		case (bcast.act)
			spq_pkg::OP_PUSH:   count_d = count_q + spq_pkg::CNT_BITS'(1);
			spq_pkg::OP_POP:    count_d = count_q - spq_pkg::CNT_BITS'(1);
			spq_pkg::OP_REMOVE: begin
				if (found) begin
					count_d = count_q - spq_pkg::CNT_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Report the queue as it stands after the operation; zero front when empty.
	always_comb begin
		rsp_d.front_key   = (count_d != '0) ? nxt[0].key : '0;
		rsp_d.front_tag   = (count_d != '0) ? nxt[0].tag : '0;
		rsp_d.entry_count = count_d;
		rsp_d.is_empty    = (count_d == '0);
		rsp_d.found       = found;
		rsp_d.status      = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response word until it is taken.
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SPQ_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || (count_q <= spq_pkg::CNT_BITS'(N)), "count above depth")
	`SPQ_ASSERT(a_push_grows, clk, arst_n, (acc && req.opcode == spq_pkg::OP_PUSH && !full) |=> (count_q == $past(count_q) + spq_pkg::CNT_BITS'(1)), "push did not grow count")
	`SPQ_ASSERT(a_empty_flag, clk, arst_n, rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)), "empty flag disagrees with count")
	`SPQ_ASSERT(a_found_ok, clk, arst_n, (acc && found) |-> (status == spq_pkg::ST_OK && count_d != count_q), "found without a removal")

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

// Testbench for the sorted priority queue.
// An initial block builds a list of request words (a short directed opening,
// then long random runs), a clocked driver presents them on the request
// channel and a clocked monitor takes response words. A queue model inside
// the bench is updated as each request is accepted and the response it
// predicts is stored in order. Every response is checked against the oldest
// stored prediction, field by field.

module tb_top;

	import spq_pkg::*;

	// A pending request word, with a flag that makes the driver wait until
	// every predicted response has been taken before sending it.
	typedef struct {
		req_t word;
		bit   drain;
	} pending_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	pending_t send_words[$];
	rsp_t     want_words[$];

	// Queue model: entries in priority order, slot 0 at the front.
	entry_t held_slots[DEPTH];
	int     held_n      = 0;

	int     words_sent  = 0;
	int     words_seen  = 0;
	int     mismatches  = 0;

	sorted_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Close the gap left by the entry at pos.
	function automatic void drop_entry(input int pos);
		int i;
		for (i = pos; i + 1 < held_n; i++)
			held_slots[i] = held_slots[i + 1];
		held_n--;
	endfunction

	// Apply one request word to the queue model and work out its response.
	function automatic rsp_t apply_queue_op(input req_t w);
		rsp_t r;
		int   pos;
		int   i;
		r        = '0;
		r.status = ST_OK;
		r.found  = 1'b0;
		case (w.opcode)
			OP_PUSH: begin
				if (held_n >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// Slot in before the first strictly larger key, so equal keys
					// keep arrival order.
					pos = 0;
					while (pos < held_n && !(w.item_key < held_slots[pos].key))
						pos++;
					for (i = held_n; i > pos; i--)
						held_slots[i] = held_slots[i - 1];
					held_slots[pos].key = w.item_key;
					held_slots[pos].tag = w.item_tag;
					held_n++;
				end
			end
			OP_POP: begin
				if (held_n == 0)
					r.status = ST_EMPTY;
				else
					drop_entry(0);
			end
			OP_REMOVE: begin
				if (held_n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// Take the first match from the front, the front itself included.
					for (i = 0; i < held_n; i++) begin
						if (held_slots[i].key == w.item_key &&
						    held_slots[i].tag == w.item_tag) begin
							drop_entry(i);
							r.found = 1'b1;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		if (held_n > 0) begin
			r.front_key = held_slots[0].key;
			r.front_tag = held_slots[0].tag;
		end
		r.entry_count = CNT_BITS'(held_n);
		r.is_empty    = (held_n == 0);
		return r;
	endfunction

	task automatic compare_word(input rsp_t got, input rsp_t want);
		if (got.front_key !== want.front_key)
			note_mismatch($sformatf("word %0d front_key %0h, want %0h",
				words_seen, got.front_key, want.front_key));
		if (got.front_tag !== want.front_tag)
			note_mismatch($sformatf("word %0d front_tag %0h, want %0h",
				words_seen, got.front_tag, want.front_tag));
		if (got.entry_count !== want.entry_count)
			note_mismatch($sformatf("word %0d entry_count %0d, want %0d",
				words_seen, got.entry_count, want.entry_count));
		if (got.is_empty !== want.is_empty)
			note_mismatch($sformatf("word %0d is_empty %0b, want %0b",
				words_seen, got.is_empty, want.is_empty));
		if (got.found !== want.found)
			note_mismatch($sformatf("word %0d found %0b, want %0b",
				words_seen, got.found, want.found));
		if (got.status !== want.status)
			note_mismatch($sformatf("word %0d status %0d, want %0d",
				words_seen, got.status, want.status));
	endtask

	task automatic queue_word(input op_t op, input logic [KEY_BITS-1:0] key,
	                          input logic [TAG_BITS-1:0] tag, input bit drain);
		pending_t p;
		p.word.opcode   = op;
		p.word.item_key = key;
		p.word.item_tag = tag;
		p.drain         = drain;
		send_words.push_back(p);
	endtask

	// Driver: predict on acceptance, then load the next word or idle.
	// Valid is assigned once per edge so it never drops for a cycle by accident.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				want_words.push_back(apply_queue_op(req));
				words_sent++;
			end
			if (!req_valid || req_ready) begin
				// Hold a draining word back until the response side has caught up;
				// skip idling altogether through the calm stretch.
				if (send_words.size() != 0 &&
				    !(send_words[0].drain && want_words.size() != 0) &&
				    ((words_sent >= 800 && words_sent < 1100) ||
				     $urandom_range(0, 99) >= 11)) begin
					req       <= send_words[0].word;
					req_valid <= 1'b1;
					void'(send_words.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted response word, then stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (want_words.size() == 0)
					note_mismatch($sformatf("response word %0d with nothing predicted",
						words_seen));
				else
					compare_word(rsp, want_words.pop_front());
				words_seen++;
			end
			rsp_ready <= (words_seen >= 800 && words_seen < 1100) ||
			             ($urandom_range(0, 99) >= 11);
		end
	end

	initial begin
		int                  n;
		int                  push_pct;
		int                  pick;
		op_t                 op;
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;

		// Empty queue: errors on pop and remove, zeroed front on every word.
		queue_word(OP_POP,    16'h0000, 16'h0000, 1'b0);
		queue_word(OP_REMOVE, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_word(OP_NOP,    16'h1234, 16'h5678, 1'b0);
		// Fill to the brim: extremes and a run of equal keys.
		queue_word(OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_word(OP_PUSH, 16'h0000, 16'h0000, 1'b0);
		queue_word(OP_PUSH, 16'h0005, 16'h0001, 1'b0);
		queue_word(OP_PUSH, 16'h0005, 16'h0002, 1'b0);
		queue_word(OP_PUSH, 16'h0005, 16'h0003, 1'b0);
		queue_word(OP_PUSH, 16'h8000, 16'hAAAA, 1'b0);
		queue_word(OP_PUSH, 16'h7FFF, 16'h5555, 1'b0);
		for (n = 0; n < 9; n++)
			queue_word(OP_PUSH, 16'($urandom), 16'($urandom), 1'b0);
		// Full: drop the push.
		queue_word(OP_PUSH,   16'h0001, 16'h4321, 1'b0);
		// Key matches but tag does not: no change.
		queue_word(OP_REMOVE, 16'h0005, 16'h0009, 1'b0);
		// Remove the front entry, then one from the middle.
		queue_word(OP_REMOVE, 16'h0000, 16'h0000, 1'b0);
		queue_word(OP_REMOVE, 16'h0005, 16'h0002, 1'b0);
		queue_word(OP_POP,    16'hFFFF, 16'h0000, 1'b0);

		// Random runs of 50 words, each with its own push mix so the queue
		// swings between empty and full. Keys and tags come mostly from a
		// small pool so removes find their entries.
		push_pct = 50;
		for (n = 0; n < 1850; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0:       push_pct = 35;
					1:       push_pct = 55;
					default: push_pct = 80;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < push_pct) begin
				op = OP_PUSH;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					op = OP_POP;
				else if (pick < 90)
					op = OP_REMOVE;
				else
					op = OP_NOP;
			end
			if ($urandom_range(0, 9) < 7) begin
				key = KEY_BITS'($urandom_range(0, 7));
				if ($urandom_range(0, 3) == 0)
					key = key | 16'hFFF8;
				tag = TAG_BITS'($urandom_range(0, 3));
				if ($urandom_range(0, 3) == 0)
					tag = tag | 16'hFFFC;
			end else begin
				key = KEY_BITS'($urandom);
				tag = TAG_BITS'($urandom);
			end
			queue_word(op, key, tag, (n == 400 || n == 1300));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain, looking between edges so the driver and monitor have settled,
		// then keep the clock running so a stray response word can still be caught.
		while (send_words.size() != 0 || req_valid || want_words.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (want_words.size() != 0)
			note_mismatch($sformatf("%0d responses never arrived", want_words.size()));
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Timeout: far beyond the slowest correct run.
	initial begin
		#2400000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
